// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// ----- rtl/core/i2cms_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master bit sequencer.
// ---------------------------------------------------------------------------
package i2cms_pkg;

    // tick counter width; phase length saturates at 2**TICK_W
    localparam int unsigned TICK_W = 16;
    localparam int unsigned CMP_W  = (TICK_W + 1 > 17) ? TICK_W + 1 : 17;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd6;

    // APB register map
    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_PHASE_TICKS = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // last phase of each sequence
    localparam logic [4:0] LAST_PH_SHORT = 5'd2;
    localparam logic [4:0] LAST_PH_WRITE = 5'd17;
    localparam logic [4:0] LAST_PH_READ  = 5'd19;

    // special phases
    localparam logic [4:0] PH_WR_ACK     = 5'd17;
    localparam logic [4:0] PH_RD_ACK_HI  = 5'd18;
    localparam logic [4:0] PH_RD_ACK_GAP = 5'd16;

    // bit mask for the MSB of a byte
    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       master_ack;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       slave_nack;
    } t_res_word;

    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_hold;

endpackage

// ----- rtl/core/i2cms_if.sv -----
// ---------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface i2cms_in_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_out_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/i2c_master_bit_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// Open-drain I2C master bit sequencer, one command word per timer tick.
// ---------------------------------------------------------------------------
// Each word on the command channel is one timer tick. An idle sequencer
// starts the command it carries (start, stop, write byte, read byte) on
// that same tick; commands seen while busy are ignored. Every bus phase
// lasts phase_ticks ticks (register at byte address 0, reset 6, zero acts
// as one). Each command word yields exactly one result word with the SCL
// and SDA drive levels for that tick, busy/done flags, the last received
// byte and the last slave ack. Throughput is one word per clock while the
// result channel is not stalled; each word passes the input register and
// the result register with the sequencer logic between them. Write
// phase_ticks only while no word is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_bit_sequencer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    i2cms_in_if.sink                       i_cmd_ch,
    i2cms_out_if.source                    o_res_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cms_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import i2cms_pkg::*;

    logic [15:0] w_phase_ticks;
    t_hold       w_hold;
    t_res_word   w_res;
    logic        w_out_free;
    logic        w_step;

    // a held word steps when the result register can take its result
    assign w_step = w_hold.valid && w_out_free;

    i2cms_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_phase_ticks (w_phase_ticks)
    );

    i2cms_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ch      (i_cmd_ch),
        .i_advance (w_step),
        .o_hold    (w_hold)
    );

    i2cms_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_word        (w_hold.word),
        .i_phase_ticks (w_phase_ticks),
        .o_res         (w_res)
    );

    i2cms_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_ch    (o_res_ch)
    );

    // done only ever on a busy tick
    `ASSERT_IMPLIES(a_done_busy, i_clk, i_rst_n, o_res_ch.valid && o_res_ch.data.done_res, o_res_ch.data.busy_res, "done without busy")
    // a stepped word shows up in the result register next cycle
    `ASSERT_NEXT(a_step_out, i_clk, i_rst_n, w_step, o_res_ch.valid, "stepped word lost")
    // stepping never overwrites a result that is still stalled
    `ASSERT_IMPLIES(a_no_overrun, i_clk, i_rst_n, w_step, !o_res_ch.valid || o_res_ch.ready, "result overrun")

endmodule

// ----- rtl/core/i2cms_apb_regs.sv -----
// ---------------------------------------------------------------------------
// i2cms_apb_regs
// APB register file: phase_ticks.
// ---------------------------------------------------------------------------
module i2cms_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cms_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [15:0]                    o_phase_ticks
);
    import i2cms_pkg::*;

    logic [15:0] r_phase_ticks;
    logic        w_hit;

    assign pready = 1'b1;
    assign w_hit  = (paddr[2] == REG_PHASE_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    assign prdata        = w_hit ? {16'b0, r_phase_ticks} : 32'b0;
    assign o_phase_ticks = r_phase_ticks;

endmodule

// ----- rtl/core/i2cms_in_stage.sv -----
// ---------------------------------------------------------------------------
// i2cms_in_stage
// Input register: holds one accepted command word until it is stepped.
// ---------------------------------------------------------------------------
module i2cms_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cms_in_if.sink          i_ch,
    input  logic              i_advance,
    output i2cms_pkg::t_hold  o_hold
);
    import i2cms_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign i_ch.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ch.valid && i_ch.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ch.valid && i_ch.ready) begin
            r_word <= i_ch.data;
        end
    end

    assign o_hold.valid = r_valid;
    assign o_hold.word  = r_word;

endmodule

// ----- rtl/core/i2cms_seq.sv -----
// ---------------------------------------------------------------------------
// i2cms_seq
// Bus phase sequencer: one tick of state update per stepped word.
// ---------------------------------------------------------------------------
module i2cms_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  i2cms_pkg::t_in_word   i_word,
    input  logic [15:0]           i_phase_ticks,
    output i2cms_pkg::t_res_word  o_res
);
    import i2cms_pkg::*;

    t_op               r_op,    n_op;
    logic [4:0]        r_ph,    n_ph;
    logic [TICK_W-1:0] r_tick,  n_tick;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_rx,    n_rx;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;
    logic              r_nack,  n_nack;
    logic              r_ack,   n_ack;

    // effective state for this tick (after a possible launch)
    t_op               c_op;
    logic [4:0]        c_ph;
    logic [TICK_W-1:0] c_tick;
    logic [7:0]        c_shift;
    logic              c_ack;
    logic              w_cmd_ok, w_launch, w_active;

    logic [CMP_W-1:0]  w_len, w_cap, w_len_eff, w_cnt1;
    logic              w_last_tick, w_last_phase, w_done;
    logic              w_lvl_scl, w_lvl_sda;
    logic [4:0]        w_last_ph;

    assign w_cmd_ok = (i_word.command == OP_START) || (i_word.command == OP_STOP) ||
                      (i_word.command == OP_WRITE) || (i_word.command == OP_READ);
    assign w_launch = (r_op == OP_NONE) && w_cmd_ok;

    always_comb begin
        c_op    = r_op;
        c_ph    = r_ph;
        c_tick  = r_tick;
        c_shift = r_shift;
        c_ack   = r_ack;
        if (w_launch) begin
            c_op    = t_op'(i_word.command);
            c_ph    = 5'd0;
            c_tick  = '0;
            c_shift = (t_op'(i_word.command) == OP_WRITE) ? i_word.tx_byte : 8'd0;
            c_ack   = i_word.master_ack;
        end
    end

    assign w_active = (c_op != OP_NONE);

    // phase length: zero counts as one, saturate at 2**TICK_W
    assign w_len       = (i_phase_ticks == 16'd0) ? CMP_W'(1) : CMP_W'(i_phase_ticks);
    assign w_cap       = CMP_W'(1) << TICK_W;
    assign w_len_eff   = (w_len > w_cap) ? w_cap : w_len;
    assign w_cnt1      = CMP_W'(c_tick) + CMP_W'(1);
    assign w_last_tick = (w_cnt1 >= w_len_eff);

    always_comb begin
        unique case (c_op)
            OP_WRITE: w_last_ph = LAST_PH_WRITE;
            OP_READ:  w_last_ph = LAST_PH_READ;
            default:  w_last_ph = LAST_PH_SHORT;
        endcase
    end

    assign w_last_phase = (c_ph == w_last_ph);
    assign w_done       = w_active && w_last_tick && w_last_phase;

    // output block: bus levels of the current phase
    always_comb begin
        w_lvl_scl = r_scl;
        w_lvl_sda = r_sda;
        unique case (c_op)
            OP_START: begin
                w_lvl_scl = (c_ph != 5'd0);
                w_lvl_sda = (c_ph == 5'd0) ? r_sda : (c_ph == 5'd1);
            end
            OP_STOP: begin
                w_lvl_scl = (c_ph != 5'd0);
                w_lvl_sda = (c_ph == LAST_PH_SHORT);
            end
            OP_WRITE: begin
                w_lvl_scl = c_ph[0];
                w_lvl_sda = c_ph[4] ? 1'b1 : |((c_shift << c_ph[3:1]) & MSB_MASK);
            end
            OP_READ: begin
                if (c_ph <= PH_RD_ACK_GAP) begin
                    w_lvl_scl = c_ph[4] ? 1'b1 : c_ph[0];
                    w_lvl_sda = 1'b1;
                end else begin
                    w_lvl_scl = (c_ph == PH_RD_ACK_HI);
                    w_lvl_sda = c_ack;
                end
            end
            default: begin
                w_lvl_scl = r_scl;
                w_lvl_sda = r_sda;
            end
        endcase
    end

    // next-state block
    always_comb begin
        n_op    = c_op;
        n_ph    = c_ph;
        n_tick  = c_tick;
        n_shift = c_shift;
        n_ack   = c_ack;
        n_rx    = r_rx;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        if (w_active) begin
            // read sample on first tick of SCL high
            if (c_op == OP_READ && !c_ph[4] && c_ph[0] && c_tick == '0) begin
                n_shift = {c_shift[6:0], i_word.sda_in};
            end
            if (c_op == OP_WRITE && c_ph == PH_WR_ACK && w_last_tick) begin
                n_nack = i_word.sda_in;
            end
            n_scl = w_lvl_scl;
            n_sda = w_lvl_sda;
            if (w_last_tick) begin
                n_tick = '0;
                n_ph   = c_ph + 5'd1;
                if (w_last_phase) begin
                    n_ph = 5'd0;
                    n_op = OP_NONE;
                    unique case (c_op)
                        OP_START: begin n_scl = 1'b0; n_sda = 1'b0; end
                        OP_STOP:  begin n_scl = 1'b1; n_sda = 1'b1; end
                        OP_WRITE: begin n_scl = 1'b0; n_sda = 1'b1; end
                        OP_READ:  begin
                            n_scl = 1'b0;
                            n_sda = c_ack;
                            n_rx  = n_shift;
                        end
                        default:  begin n_scl = r_scl; n_sda = r_sda; end
                    endcase
                end
            end else begin
                n_tick = c_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_NONE;
            r_ph    <= 5'd0;
            r_tick  <= '0;
            r_shift <= 8'd0;
            r_rx    <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_nack  <= 1'b0;
            r_ack   <= 1'b0;
        end else if (i_step) begin
            r_op    <= n_op;
            r_ph    <= n_ph;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_rx    <= n_rx;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_ack   <= n_ack;
        end
    end

    assign o_res.scl_level  = w_active ? w_lvl_scl : r_scl;
    assign o_res.sda_level  = w_active ? w_lvl_sda : r_sda;
    assign o_res.busy_res   = w_active;
    assign o_res.done_res   = w_done;
    assign o_res.rx_byte    = n_rx;
    assign o_res.slave_nack = n_nack;

endmodule

// ----- rtl/core/i2cms_out_stage.sv -----
// ---------------------------------------------------------------------------
// i2cms_out_stage
// Result register: holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module i2cms_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  i2cms_pkg::t_res_word  i_res,
    output logic                  o_free,
    i2cms_out_if.source           o_ch
);
    import i2cms_pkg::*;

    logic      r_valid;
    t_res_word r_word;

    assign o_free = !r_valid || o_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_res;
        end
    end

    assign o_ch.valid = r_valid;
    assign o_ch.data  = r_word;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit sequencer: random timer-tick
// words with random idling on both channels, predicted results checked in
// order, and phase length changes, also within a phase.
// ---------------------------------------------------------------------------
import i2cms_pkg::*;

// Tracks the sequencer state, predicts the result word of each tick word and
// checks the result words in arrival order.
class seq_scoreboard;
    localparam int unsigned DATA_PHASES = 16;

    logic [15:0] phase_ticks;
    t_op         op_now;
    logic [4:0]  phase;
    logic [15:0] ticks;
    logic [7:0]  shifter;
    logic [7:0]  rx_hold;
    logic        scl_q;
    logic        sda_q;
    logic        nack_q;
    logic        ack_sel;
    t_res_word   expect_q[$];
    int          errors;

    function new();
        phase_ticks = PHASE_TICKS_RST;
        op_now      = OP_NONE;
        phase       = '0;
        ticks       = '0;
        shifter     = '0;
        rx_hold     = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        nack_q      = 1'b0;
        ack_sel     = 1'b0;
        errors      = 0;
    endfunction

    function void set_phase_ticks(logic [15:0] value);
        phase_ticks = value;
    endfunction

    function int pending();
        return expect_q.size();
    endfunction

    function logic [4:0] last_phase(t_op op);
        case (op)
            OP_WRITE: return LAST_PH_WRITE;
            OP_READ:  return LAST_PH_READ;
            default:  return LAST_PH_SHORT;
        endcase
    endfunction

    // one accepted tick word -> one expected result word
    function void note_word(t_in_word w);
        t_res_word   r;
        logic [16:0] len;
        logic        last;
        logic [4:0]  ph;
        logic        s_scl;
        logic        s_sda;

        if (op_now == OP_NONE && w.command >= OP_START && w.command <= OP_READ) begin
            op_now  = t_op'(w.command);
            phase   = '0;
            ticks   = '0;
            shifter = (w.command == OP_WRITE) ? w.tx_byte : 8'h00;
            ack_sel = w.master_ack;
        end

        r       = '0;
        s_scl   = scl_q;
        s_sda   = sda_q;
        if (op_now != OP_NONE) begin
            // zero acts as one; 16-bit register never reaches the 2**16 cap
            len  = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
            last = ({1'b0, ticks} + 17'd1) >= len;
            ph   = phase;
            r.busy_res = 1'b1;

            case (op_now)
                OP_START: begin
                    s_scl = (ph != 5'd0);
                    s_sda = (ph == 5'd0) ? sda_q : (ph == 5'd1);
                end
                OP_STOP: begin
                    s_scl = (ph != 5'd0);
                    s_sda = (ph == LAST_PH_SHORT);
                end
                OP_WRITE: begin
                    s_scl = ph[0];
                    s_sda = (ph < DATA_PHASES) ? shifter[3'd7 - ph[3:1]] : 1'b1;
                end
                OP_READ: begin
                    if (ph <= PH_RD_ACK_GAP) begin
                        s_scl = (ph == PH_RD_ACK_GAP) ? 1'b1 : ph[0];
                        s_sda = 1'b1;
                    end else begin
                        s_scl = (ph == PH_RD_ACK_HI);
                        s_sda = ack_sel;
                    end
                end
                default: ;
            endcase

            // read data on first tick of SCL high, write ack on last ack tick
            if (op_now == OP_READ && ph < DATA_PHASES && ph[0] && ticks == 16'd0)
                shifter = {shifter[6:0], w.sda_in};
            if (op_now == OP_WRITE && ph == PH_WR_ACK && last)
                nack_q = w.sda_in;

            scl_q = s_scl;
            sda_q = s_sda;

            if (last) begin
                ticks = '0;
                if (ph == last_phase(op_now)) begin
                    r.done_res = 1'b1;
                    phase      = '0;
                    case (op_now)
                        OP_START: begin scl_q = 1'b0; sda_q = 1'b0; end
                        OP_STOP:  begin scl_q = 1'b1; sda_q = 1'b1; end
                        OP_WRITE: begin scl_q = 1'b0; sda_q = 1'b1; end
                        default: begin
                            scl_q   = 1'b0;
                            sda_q   = ack_sel;
                            rx_hold = shifter;
                        end
                    endcase
                    op_now = OP_NONE;
                end else begin
                    phase = ph + 5'd1;
                end
            end else begin
                ticks = ticks + 16'd1;
            end
        end

        r.scl_level  = s_scl;
        r.sda_level  = s_sda;
        r.rx_byte    = rx_hold;
        r.slave_nack = nack_q;
        expect_q.push_back(r);
    endfunction

    function void fail_note(string msg);
        errors++;
        if (errors <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
            fail_note($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function void check_word(t_res_word got);
        t_res_word want;
        if (expect_q.size() == 0) begin
            fail_note($sformatf("unexpected result word %h", got));
            return;
        end
        want = expect_q.pop_front();
        cmp_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        cmp_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
        cmp_field("rx_byte", want.rx_byte, got.rx_byte);
        cmp_field("slave_nack", 8'(want.slave_nack), 8'(got.slave_nack));
    endfunction
endclass

module tb;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 4;      // covers the input and result registers, plus margin
    localparam int RAND_WORDS   = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    bit                    calm;
    int                    quiet;

    i2cms_in_if  cmd_if();
    i2cms_out_if res_if();

    seq_scoreboard sb = new();

    i2c_master_bit_sequencer_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_if),
        .o_res_ch (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sample both channels at the edge, input first so a same-edge result
    // can still find its expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_word(cmd_if.data);
            if (res_if.valid && res_if.ready)
                sb.check_word(res_if.data);
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (cmd_if.valid && cmd_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result sink: random stall bursts, one long hold-off to back up the pipe
    initial begin : result_sink
        int hold_left;
        int taken;
        bit long_done;
        hold_left = 0;
        taken     = 0;
        long_done = 0;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (res_if.valid && res_if.ready)
                taken++;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!long_done && taken >= 400) begin
                long_done = 1;
                hold_left = 99;
                res_if.ready <= 1'b0;
            end else if (calm || $urandom_range(0, 7) != 0) begin
                res_if.ready <= 1'b1;
            end else begin
                hold_left = $urandom_range(0, 7);
                res_if.ready <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // one tick word; an optional idle burst goes before it
    task automatic send_word(t_in_word w);
        if (!calm && $urandom_range(0, 9) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= w;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    // a command word followed by filler ticks carrying another command
    task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack, int n_ticks,
                           logic [2:0] filler);
        t_in_word w;
        w.command    = op;
        w.tx_byte    = tx;
        w.master_ack = ack;
        w.sda_in     = 1'($urandom_range(0, 1));
        send_word(w);
        for (int i = 1; i < n_ticks; i++) begin
            w.command    = filler;
            w.tx_byte    = 8'($urandom_range(0, 255));
            w.master_ack = 1'($urandom_range(0, 1));
            w.sda_in     = 1'($urandom_range(0, 1));
            send_word(w);
        end
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            w.command = OP_NONE;
        else if (pick < 92)
            w.command = 3'($urandom_range(OP_START, OP_READ));
        else
            w.command = 3'($urandom_range(5, 7));   // unknown codes act as none
        w.tx_byte    = 8'($urandom_range(0, 255));
        w.master_ack = 1'($urandom_range(0, 1));
        w.sda_in     = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // drop valid, let every expected word arrive, then cover the latency
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // APB write: setup then access; the register takes it on the access edge
    task automatic reg_write(logic [15:0] ticks_val);
        logic [31:0] value;
        value = {16'($urandom_range(0, 65535)), ticks_val};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_PHASE_TICKS);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_phase_ticks(value[15:0]);
    endtask

    initial begin : stimulus
        logic [15:0] settings [6];
        settings = '{16'd2, 16'd0, 16'd3, 16'd1, 16'd6, 16'd1};
        calm = 0;
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start at the reset phase length, a stop offered while busy
        run_cmd(OP_START, 8'h00, 1'b0, 3 * 6, OP_STOP);
        settle();

        // zero phase length: every phase one tick
        reg_write(16'd0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 18, OP_NONE);
        run_cmd(OP_WRITE, 8'h00, 1'b1, 18, OP_READ);
        run_cmd(OP_READ, 8'hFF, 1'b0, 20, OP_WRITE);
        run_cmd(OP_READ, 8'h00, 1'b1, 20, OP_NONE);
        run_cmd(3'd7, 8'hA5, 1'b1, 1, OP_NONE);
        run_cmd(3'd5, 8'h5A, 1'b0, 1, OP_NONE);
        run_cmd(OP_STOP, 8'h00, 1'b0, 3, OP_NONE);
        settle();

        // longest phase, then shrink it mid-phase: the phase ends next tick
        reg_write(16'hFFFF);
        run_cmd(OP_START, 8'h00, 1'b0, 12, OP_NONE);
        settle();
        reg_write(16'd1);
        run_cmd(OP_NONE, 8'h00, 1'b0, 8, OP_NONE);
        settle();

        // random ticks over several phase lengths, last stretch without idling
        foreach (settings[k]) begin
            reg_write(settings[k]);
            if (k == 5)
                calm = 1;
            repeat (RAND_WORDS) send_word(rand_word());
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_if.sv
rtl/core/i2cms_apb_regs.sv
rtl/core/i2cms_in_stage.sv
rtl/core/i2cms_seq.sv
rtl/core/i2cms_out_stage.sv
rtl/core/i2c_master_bit_sequencer_unit.sv
verif/tb.sv
